FILE: hdl/grg_pkg.sv
package grg_pkg;

	localparam int IN_WIDTH_DEF  = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TRIG_FRAC     = 30;
	localparam int TRIG_W        = 32;
	localparam int Z_W           = 32;

	localparam logic [TRIG_W-1:0] TRIG_ONE = 32'h4000_0000;

	typedef enum logic [1:0] {
		ZSEL_ZERO,
		ZSEL_ONE,
		ZSEL_SIN,
		ZSEL_DIV
	} zsel_t;

endpackage

FILE: hdl/givens_rotation_generator_top.sv
// Givens rotation generator: takes (a, b) in signed fixed point with FRAC_BITS fraction bits
// and returns radius r, cosine and sine in Q2.30 and the reconstruction value z, rounded to
// nearest as in the DROTG scheme. Fully pipelined: one transaction per cycle in and out while the
// output is not held, with the bit-per-stage square root (IN_WIDTH stages), the cosine/sine
// divider (30 stages) and the 1/c divider (FRAC_BITS + 31 stages). The whole pipeline holds
// while a result waits on m_tready.
module givens_rotation_generator_top #(
	parameter int IN_WIDTH  = grg_pkg::IN_WIDTH_DEF,
	parameter int FRAC_BITS = grg_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// a_in, b_in
	input  logic [((2*IN_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// radius, cosine, sine, recon
	output logic [((IN_WIDTH+1+3*32+7)/8)*8-1:0] m_tdata
);

	localparam int W    = IN_WIDTH;
	localparam int SW   = 2*W;
	localparam int H    = (W+1)/2;
	localparam int L    = W-H;
	localparam int RW   = W+3;
	localparam int RADW = W+1;
	localparam int TF   = grg_pkg::TRIG_FRAC;
	localparam int TW   = grg_pkg::TRIG_W;
	localparam int ZW   = grg_pkg::Z_W;
	localparam int CW   = TF+1;
	localparam int NZ   = FRAC_BITS+TF+1;
	localparam int ZQW  = NZ+2;
	localparam int ZSH  = TF-FRAC_BITS;
	localparam int OUT_BW = ((RADW+3*32+7)/8)*8;
	localparam int SQS  = 2*W+5;
	localparam int D1S  = RADW+7;
	localparam int D2S  = RADW+3+3*TW;
	localparam logic [ZW-1:0] ZHALF   = (ZW'(1) << ZSH) >> 1;
	localparam logic [ZW-1:0] Z_ONE   = ZW'(1) << FRAC_BITS;
	localparam logic [ZQW-1:0] ZMAX_N = ZQW'(64'h8000_0000);
	localparam logic [ZQW-1:0] ZMAX_P = ZQW'(64'h7fff_ffff);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// decode
	logic         valid_s1;
	logic [W-1:0] am_s1, bm_s1;
	logic         an_s1, bn_s1, az_s1, bz_s1;
	logic [W-1:0] a_in, b_in;
	assign a_in = s_tdata[W-1:0];
	assign b_in = s_tdata[2*W-1:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= a_in[W-1];
			bn_s1 <= b_in[W-1];
			am_s1 <= a_in[W-1] ? W'(~a_in + W'(1)) : a_in;
			bm_s1 <= b_in[W-1] ? W'(~b_in + W'(1)) : b_in;
			az_s1 <= a_in == '0;
			bz_s1 <= b_in == '0;
		end
	end

	// partial products
	logic           valid_s2;
	logic [W-1:0]   am_s2, bm_s2;
	logic           an_s2, bn_s2, az_s2, bz_s2, abig_s2;
	logic [2*H-1:0] pall_s2, pbll_s2;
	logic [W-1:0]   palh_s2, pblh_s2;
	logic [2*L-1:0] pahh_s2, pbhh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s2   <= am_s1;
			bm_s2   <= bm_s1;
			an_s2   <= an_s1;
			bn_s2   <= bn_s1;
			az_s2   <= az_s1;
			bz_s2   <= bz_s1;
			abig_s2 <= am_s1 > bm_s1;
			pall_s2 <= (2*H)'(am_s1[H-1:0]) * (2*H)'(am_s1[H-1:0]);
			palh_s2 <= W'(am_s1[H-1:0]) * W'(am_s1[W-1:H]);
			pahh_s2 <= (2*L)'(am_s1[W-1:H]) * (2*L)'(am_s1[W-1:H]);
			pbll_s2 <= (2*H)'(bm_s1[H-1:0]) * (2*H)'(bm_s1[H-1:0]);
			pblh_s2 <= W'(bm_s1[H-1:0]) * W'(bm_s1[W-1:H]);
			pbhh_s2 <= (2*L)'(bm_s1[W-1:H]) * (2*L)'(bm_s1[W-1:H]);
		end
	end

	// sum of squares
	logic            valid_s3;
	logic [SW-1:0]   sum_s3;
	logic [SQS-1:0]  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3 <= (SW'(pahh_s2) << (2*H)) + (SW'(palh_s2) << (H+1)) + SW'(pall_s2)
				+ (SW'(pbhh_s2) << (2*H)) + (SW'(pblh_s2) << (H+1)) + SW'(pbll_s2);
			side_s3 <= {abig_s2, az_s2, bz_s2, bn_s2, an_s2, bm_s2, am_s2};
		end
	end

	// square root, one result bit per stage
	logic [SW-1:0]  sq_s_sn    [0:W];
	logic [RW-1:0]  sq_rem_sn  [0:W];
	logic [W-1:0]   sq_root_sn [0:W];
	logic [SQS-1:0] sq_side_sn [0:W];
	logic           sq_valid_sn[0:W];

	assign sq_s_sn[0]     = sum_s3;
	assign sq_rem_sn[0]   = '0;
	assign sq_root_sn[0]  = '0;
	assign sq_side_sn[0]  = side_s3;
	assign sq_valid_sn[0] = valid_s3;

	for (genvar k = 0; k < W; k++) begin : g_sqrt
		logic [RW-1:0] rem2, trial;
		assign rem2  = {sq_rem_sn[k][RW-3:0], sq_s_sn[k][SW-1:SW-2]};
		assign trial = RW'({sq_root_sn[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_valid_sn[k+1] <= 1'b0;
			end else if (en) begin
				sq_valid_sn[k+1] <= sq_valid_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s_sn[k+1]    <= sq_s_sn[k] << 2;
				sq_side_sn[k+1] <= sq_side_sn[k];
				if (rem2 >= trial) begin
					sq_rem_sn[k+1]  <= rem2 - trial;
					sq_root_sn[k+1] <= (sq_root_sn[k] << 1) | W'(1);
				end else begin
					sq_rem_sn[k+1]  <= rem2;
					sq_root_sn[k+1] <= sq_root_sn[k] << 1;
				end
			end
		end
	end

	// round root
	logic           valid_s4;
	logic [W-1:0]   rm_s4;
	logic [SQS-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sq_valid_sn[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rm_s4   <= sq_root_sn[W] + W'(sq_rem_sn[W] > RW'(sq_root_sn[W]));
			side_s4 <= sq_side_sn[W];
		end
	end

	// signs, radius and integer part of the ratios
	logic [W-1:0] am_4, bm_4;
	logic         an_4, bn_4, bz_4, az_4, abig_4, rneg_4;
	assign {abig_4, az_4, bz_4, bn_4, an_4, bm_4, am_4} = side_s4;
	assign rneg_4 = abig_4 ? an_4 : bn_4;

	logic                valid_s5;
	logic [W-1:0]        rm_s5;
	logic [W-1:0]        remc_s5, rems_s5;
	logic [D1S-1:0]      side_s5;
	logic [RADW-1:0]     rad_5;

	always_comb begin
		logic [RADW-1:0] mag;
		logic            neg;
		priority if (bz_4) begin
			mag = RADW'(am_4);
			neg = an_4;
		end else if (az_4) begin
			mag = RADW'(bm_4);
			neg = bn_4;
		end else begin
			mag = RADW'(rm_s4);
			neg = rneg_4;
		end
		rad_5 = neg ? RADW'(~mag + RADW'(1)) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rm_s5   <= rm_s4;
			remc_s5 <= (am_4 >= rm_s4) ? W'(am_4 - rm_s4) : am_4;
			rems_s5 <= (bm_4 >= rm_s4) ? W'(bm_4 - rm_s4) : bm_4;
			side_s5 <= {bm_4 >= rm_s4, am_4 >= rm_s4, bn_4 ^ rneg_4, an_4 ^ rneg_4,
				abig_4, az_4, bz_4, rad_5};
		end
	end

	// cosine and sine fractions
	logic                   d1_valid;
	logic [1:0][TF-1:0]     d1_quot;
	logic [1:0]             d1_up;
	logic [D1S-1:0]         d1_side;

	grg_div #(
		.LANES (2),
		.NB    (TF),
		.DW    (W),
		.SIDE_W(D1S)
	) u_div_cs (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s5),
		.in_num   ('0),
		.in_rem   ({rems_s5, remc_s5}),
		.in_den   (rm_s5),
		.in_side  (side_s5),
		.out_valid(d1_valid),
		.out_quot (d1_quot),
		.out_up   (d1_up),
		.out_side (d1_side)
	);

	logic            q0s_6, q0c_6, sneg_6, cneg_6, abig_6, az_6, bz_6;
	logic [RADW-1:0] rad_6;
	logic [CW-1:0]   cm_6, sm_6;
	assign {q0s_6, q0c_6, sneg_6, cneg_6, abig_6, az_6, bz_6, rad_6} = d1_side;
	assign cm_6 = {q0c_6, d1_quot[0]} + CW'(d1_up[0]);
	assign sm_6 = {q0s_6, d1_quot[1]} + CW'(d1_up[1]);

	logic              valid_s6;
	logic [CW-1:0]     den_s6;
	logic [D2S-1:0]    side_s6;
	logic [D2S-1:0]    side_6_nx;

	always_comb begin : p_cs
		logic [TW-1:0]   cosv, sinv;
		logic [ZW-1:0]   zs;
		grg_pkg::zsel_t  zsel;
		priority if (bz_6) begin
			cosv = grg_pkg::TRIG_ONE;
			sinv = '0;
		end else if (az_6) begin
			cosv = '0;
			sinv = grg_pkg::TRIG_ONE;
		end else begin
			cosv = cneg_6 ? TW'(~TW'(cm_6) + TW'(1)) : TW'(cm_6);
			sinv = sneg_6 ? TW'(~TW'(sm_6) + TW'(1)) : TW'(sm_6);
		end
		zs = (ZW'(sm_6) + ZHALF) >> ZSH;
		zs = sneg_6 ? ZW'(~zs + ZW'(1)) : zs;
		priority if (bz_6) begin
			zsel = grg_pkg::ZSEL_ZERO;
		end else if (az_6) begin
			zsel = grg_pkg::ZSEL_ONE;
		end else if (abig_6) begin
			zsel = grg_pkg::ZSEL_SIN;
		end else if (cm_6 == '0) begin
			zsel = grg_pkg::ZSEL_ONE;
		end else begin
			zsel = grg_pkg::ZSEL_DIV;
		end
		side_6_nx = {zsel, cneg_6, zs, sinv, cosv, rad_6};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= (cm_6 == '0) ? CW'(1) : cm_6;
			side_s6 <= side_6_nx;
		end
	end

	// reciprocal of the cosine
	logic                d2_valid;
	logic [0:0][NZ-1:0]  d2_quot;
	logic [0:0]          d2_up;
	logic [D2S-1:0]      d2_side;

	grg_div #(
		.LANES (1),
		.NB    (NZ),
		.DW    (CW),
		.SIDE_W(D2S)
	) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s6),
		.in_num   (NZ'(1) << (NZ-1)),
		.in_rem   ('0),
		.in_den   (den_s6),
		.in_side  (side_s6),
		.out_valid(d2_valid),
		.out_quot (d2_quot),
		.out_up   (d2_up),
		.out_side (d2_side)
	);

	grg_pkg::zsel_t  zsel_7;
	logic [1:0]      zsel_bits_7;
	logic            zneg_7;
	logic [ZW-1:0]   zsin_7;
	logic [TW-1:0]   sin_7, cos_7;
	logic [RADW-1:0] rad_7;
	assign {zsel_bits_7, zneg_7, zsin_7, sin_7, cos_7, rad_7} = d2_side;
	assign zsel_7 = grg_pkg::zsel_t'(zsel_bits_7);

	logic [ZW-1:0] z_7;
	always_comb begin
		logic [ZQW-1:0] zq;
		zq = ZQW'(d2_quot[0]) + ZQW'(d2_up[0]);
		if (zneg_7) begin
			zq = (zq > ZMAX_N) ? ZMAX_N : zq;
		end else begin
			zq = (zq > ZMAX_P) ? ZMAX_P : zq;
		end
		unique case (zsel_7)
			grg_pkg::ZSEL_ZERO: z_7 = '0;
			grg_pkg::ZSEL_ONE:  z_7 = Z_ONE;
			grg_pkg::ZSEL_SIN:  z_7 = zsin_7;
			grg_pkg::ZSEL_DIV:  z_7 = zneg_7 ? ZW'(~zq[ZW-1:0] + ZW'(1)) : zq[ZW-1:0];
			default:            z_7 = '0;
		endcase
	end

	// output register
	logic            valid_s7;
	logic [RADW-1:0] rad_s7;
	logic [TW-1:0]   cos_s7, sin_s7;
	logic [ZW-1:0]   z_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s7 <= rad_7;
			cos_s7 <= cos_7;
			sin_s7 <= sin_7;
			z_s7   <= z_7;
		end
	end

	assign m_tvalid = valid_s7;
	assign m_tdata  = OUT_BW'({z_s7, sin_s7, cos_s7, rad_s7});

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(cos_s7) <= $signed(grg_pkg::TRIG_ONE)
			&& $signed(cos_s7) >= -$signed(grg_pkg::TRIG_ONE)))
		else $error("cosine out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(sin_s7) <= $signed(grg_pkg::TRIG_ONE)
			&& $signed(sin_s7) >= -$signed(grg_pkg::TRIG_ONE)))
		else $error("sine out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && !s_tready) || m_tready)
		else $error("pipeline advanced while output held");

endmodule

FILE: hdl/grg_div.sv
module grg_div #(
	parameter int LANES  = 1,
	parameter int NB     = 8,
	parameter int DW     = 8,
	parameter int SIDE_W = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [LANES-1:0][NB-1:0]       in_num,
	input  logic [LANES-1:0][DW-1:0]       in_rem,
	input  logic [DW-1:0]                  in_den,
	input  logic [SIDE_W-1:0]              in_side,
	output logic                           out_valid,
	output logic [LANES-1:0][NB-1:0]       out_quot,
	output logic [LANES-1:0]               out_up,
	output logic [SIDE_W-1:0]              out_side
);

	logic [LANES-1:0][NB-1:0] num_sn  [0:NB];
	logic [LANES-1:0][NB-1:0] quot_sn [0:NB];
	logic [LANES-1:0][DW-1:0] rem_sn  [0:NB];
	logic [DW-1:0]            den_sn  [0:NB];
	logic [SIDE_W-1:0]        side_sn [0:NB];
	logic                     valid_sn[0:NB];

	assign num_sn[0]   = in_num;
	assign quot_sn[0]  = '0;
	assign rem_sn[0]   = in_rem;
	assign den_sn[0]   = in_den;
	assign side_sn[0]  = in_side;
	assign valid_sn[0] = in_valid;

	for (genvar k = 0; k < NB; k++) begin : g_step
		logic [LANES-1:0][NB-1:0] num_nx;
		logic [LANES-1:0][NB-1:0] quot_nx;
		logic [LANES-1:0][DW-1:0] rem_nx;

		always_comb begin
			logic [DW:0] r2;
			for (int l = 0; l < LANES; l++) begin
				r2 = {rem_sn[k][l], num_sn[k][l][NB-1]};
				num_nx[l] = num_sn[k][l] << 1;
				if (r2 >= {1'b0, den_sn[k]}) begin
					rem_nx[l]  = DW'(r2 - {1'b0, den_sn[k]});
					quot_nx[l] = (quot_sn[k][l] << 1) | NB'(1);
				end else begin
					rem_nx[l]  = r2[DW-1:0];
					quot_nx[l] = quot_sn[k][l] << 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k+1] <= 1'b0;
			end else if (en) begin
				valid_sn[k+1] <= valid_sn[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_sn[k+1]  <= num_nx;
				quot_sn[k+1] <= quot_nx;
				rem_sn[k+1]  <= rem_nx;
				den_sn[k+1]  <= den_sn[k];
				side_sn[k+1] <= side_sn[k];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_up[l] = {rem_sn[NB][l], 1'b0} >= {1'b0, den_sn[NB]};
		end
	end

	assign out_valid = valid_sn[NB];
	assign out_quot  = quot_sn[NB];
	assign out_side  = side_sn[NB];

endmodule
